[src/svfd_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and codes for the serial VFD display controller.
package svfd_pkg;

  // Display geometry
  localparam int unsigned DIGITS = 16;
  localparam int unsigned ADDR_W = $clog2(DIGITS);

  // Command groups, selected by the top three bits of a byte
  localparam logic [2:0] GRP_DUTY   = 3'b111;
  localparam logic [2:0] GRP_CURSOR = 3'b101;
  localparam logic [2:0] GRP_TEST   = 3'b100;
  localparam logic [2:0] GRP_DIGITS = 3'b110;

  // Character codes
  localparam logic [6:0] CHAR_BLANK    = 7'd32;
  localparam logic [6:0] CHAR_NULL_SUB = 7'd64;
  localparam logic [6:0] CHAR_DOT      = 7'd46;
  localparam logic [6:0] CHAR_COMMA    = 7'd44;

  localparam logic [4:0] DIGITS_DEFAULT = 5'(DIGITS);
  localparam logic [3:0] CURSOR_RESET   = 4'(DIGITS - 1);
  localparam logic [ADDR_W-1:0] CURSOR_STEP = ADDR_W'(1);
  localparam logic [2:0] BIT_LAST       = 3'd7;

  // Operation handed from the decode step to the digit RAM step
  typedef enum logic [1:0] {
    OP_NONE,
    OP_POINT,
    OP_CHAR,
    OP_CLEAR
  } ram_op_t;

  // One digit RAM entry: point code above character code
  typedef struct packed {
    logic [5:0] point;
    logic [6:0] chr;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{point: 6'd0, chr: CHAR_BLANK};

  // Controller state outside the digit RAM
  typedef struct packed {
    logic              enabled;
    logic              clock_level;
    logic [7:0]        shift_byte;
    logic [2:0]        bit_count;
    logic [ADDR_W-1:0] cursor;
    logic [4:0]        duty;
    logic [4:0]        digits;
  } ctrl_t;

  localparam ctrl_t CTRL_RESET = '{
    enabled:     1'b0,
    clock_level: 1'b0,
    shift_byte:  8'd0,
    bit_count:   3'd0,
    cursor:      CURSOR_RESET,
    duty:        5'd0,
    digits:      5'd0
  };

  // RAM request from decode
  typedef struct packed {
    ram_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic [6:0]        value;
  } ram_req_t;

  // Input word
  typedef struct packed {
    logic              cmd;
    logic              enable_line;
    logic              clock_line;
    logic              data_line;
    logic [7:0]        byte_value;
    logic [ADDR_W-1:0] read_index;
  } item_t;

  // Result word
  typedef struct packed {
    logic              disp_pulse;
    logic              duty_pulse;
    logic [4:0]        intensity;
    logic [4:0]        digit_count;
    logic [ADDR_W-1:0] cursor;
    logic              is_enabled;
    logic [6:0]        read_char;
    logic [5:0]        read_point;
  } result_t;

endpackage

[src/svfd_decode.sv]
`timescale 1ns / 1ps
// Pin sampling, serial shift and byte decode for one input word.
module svfd_decode (
  input  svfd_pkg::item_t    item,
  input  svfd_pkg::ctrl_t    ctrl,
  output svfd_pkg::ctrl_t    ctrl_next,
  output svfd_pkg::ram_req_t req,
  output logic               inten_pulse
);

  logic       dec_en;
  logic [7:0] dec_byte;
  logic [7:0] shifted;
  logic [6:0] chr;

  always_comb begin
    ctrl_next   = ctrl;
    req         = '{op: svfd_pkg::OP_NONE, addr: ctrl.cursor, value: 7'd0};
    inten_pulse = 1'b0;
    dec_en      = 1'b0;
    dec_byte    = item.byte_value;
    shifted     = {ctrl.shift_byte[6:0], item.data_line};
    chr         = {1'b0, dec_byte[5:0]};

    // Sample pins or take a direct byte
    if (item.cmd) begin
      dec_en = ctrl.enabled;
    end else if (!item.enable_line) begin
      if (ctrl.enabled) begin
        ctrl_next   = svfd_pkg::CTRL_RESET;
        req.op      = svfd_pkg::OP_CLEAR;
        inten_pulse = 1'b1;
      end
      ctrl_next.enabled     = 1'b0;
      ctrl_next.clock_level = item.clock_line;
    end else begin
      ctrl_next.enabled = 1'b1;
      if (item.clock_line != ctrl.clock_level) begin
        // Shift on the falling edge, MSB first
        if (!item.clock_line) begin
          ctrl_next.shift_byte = shifted;
          ctrl_next.bit_count  = ctrl.bit_count + 3'd1;
          if (ctrl.bit_count == svfd_pkg::BIT_LAST) begin
            dec_en   = 1'b1;
            dec_byte = shifted;
          end
        end
        ctrl_next.clock_level = item.clock_line;
      end
    end

    // Decode a completed or direct byte
    chr = {1'b0, dec_byte[5:0]};
    if (chr == 7'd0) begin
      chr = svfd_pkg::CHAR_NULL_SUB;
    end
    if (dec_en) begin
      unique case (dec_byte[7:5])
        svfd_pkg::GRP_DUTY: begin
          if (ctrl.duty != dec_byte[4:0]) begin
            ctrl_next.duty = dec_byte[4:0];
            inten_pulse    = 1'b1;
          end
        end
        svfd_pkg::GRP_CURSOR: begin
          ctrl_next.cursor = dec_byte[svfd_pkg::ADDR_W-1:0];
        end
        svfd_pkg::GRP_TEST: begin
        end
        svfd_pkg::GRP_DIGITS: begin
          ctrl_next.digits = (dec_byte[4:0] == 5'd0) ? svfd_pkg::DIGITS_DEFAULT
                                                     : dec_byte[4:0];
        end
        default: begin
          req.value = chr;
          if (chr == svfd_pkg::CHAR_DOT || chr == svfd_pkg::CHAR_COMMA) begin
            req.op   = svfd_pkg::OP_POINT;
            req.addr = ctrl.cursor;
          end else begin
            ctrl_next.cursor = ctrl.cursor + svfd_pkg::CURSOR_STEP;
            req.op           = svfd_pkg::OP_CHAR;
            req.addr         = ctrl.cursor + svfd_pkg::CURSOR_STEP;
          end
        end
      endcase
    end
  end

endmodule

[src/svfd_ram.sv]
`timescale 1ns / 1ps
// Digit RAM with per-entry valid bits and two registered read ports.
module svfd_ram (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rd_en,
  input  logic [svfd_pkg::ADDR_W-1:0]         rd_addr_a,
  input  logic [svfd_pkg::ADDR_W-1:0]         rd_addr_b,
  output svfd_pkg::entry_t                    rd_data_a,
  output svfd_pkg::entry_t                    rd_data_b,
  input  logic                                wr_en,
  input  logic [svfd_pkg::ADDR_W-1:0]         wr_addr,
  input  svfd_pkg::entry_t                    wr_data,
  input  logic                                clr
);

  svfd_pkg::entry_t               mem [svfd_pkg::DIGITS];
  logic [svfd_pkg::DIGITS-1:0]    vld;

  // Write storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track written entries; drop all on clear
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Register both reads; unwritten entries read as blank
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= vld[rd_addr_a] ? mem[rd_addr_a] : svfd_pkg::ENTRY_RESET;
      rd_data_b <= vld[rd_addr_b] ? mem[rd_addr_b] : svfd_pkg::ENTRY_RESET;
    end
  end

endmodule

[src/serial_vfd_display_controller.sv]
`timescale 1ns / 1ps
// Pipeline: an accepted word is held in the s1 register for the RAM step and then
// loads the result register, which is the only path to the result handshake.
// Throughput: one word per cycle while the receiver keeps ready high; a held
// result stalls the RAM step and, one word later, the input.
// Reset: synchronous; clears control state and the RAM valid bits at once.
module serial_vfd_display_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  svfd_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output svfd_pkg::result_t result
);

  svfd_pkg::ctrl_t    ctrl;
  svfd_pkg::ctrl_t    ctrl_next;
  svfd_pkg::ram_req_t req;
  logic               inten_pulse;

  logic                              s1_valid;
  svfd_pkg::ram_req_t                s1_req;
  svfd_pkg::ctrl_t                   s1_ctrl;
  logic                              s1_inten;
  logic [svfd_pkg::ADDR_W-1:0]       s1_read_index;

  svfd_pkg::ram_op_t                 fwd_op;
  logic [svfd_pkg::ADDR_W-1:0]       fwd_addr;
  svfd_pkg::entry_t                  fwd_data;

  svfd_pkg::entry_t                  rd_tgt;
  svfd_pkg::entry_t                  rd_idx;
  svfd_pkg::entry_t                  old_tgt;
  svfd_pkg::entry_t                  old_idx;
  svfd_pkg::entry_t                  new_entry;
  logic                              wr_en;
  logic                              clr;
  logic                              disp;
  svfd_pkg::result_t                 result_next;

  logic accept;
  logic s1_adv;
  logic s1_fire;

  // Handshake
  assign s1_adv     = !result_valid || result_ready;
  assign item_ready = !s1_valid || s1_adv;
  assign accept     = item_valid && item_ready;
  assign s1_fire    = s1_valid && s1_adv;

  svfd_decode u_decode (
    .item        (item),
    .ctrl        (ctrl),
    .ctrl_next   (ctrl_next),
    .req         (req),
    .inten_pulse (inten_pulse)
  );

  svfd_ram u_ram (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (req.addr),
    .rd_addr_b (item.read_index),
    .rd_data_a (rd_tgt),
    .rd_data_b (rd_idx),
    .wr_en     (wr_en),
    .wr_addr   (s1_req.addr),
    .wr_data   (new_entry),
    .clr       (clr)
  );

  // Advance control state on every accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= svfd_pkg::CTRL_RESET;
    end else if (accept) begin
      ctrl <= ctrl_next;
    end
  end

  // Hold the decoded word for the RAM step
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req        <= req;
      s1_ctrl       <= ctrl_next;
      s1_inten      <= inten_pulse;
      s1_read_index <= item.read_index;
    end
  end

  // Capture the write that lands on the same edge as the new word's reads
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_op <= svfd_pkg::OP_NONE;
    end else if (accept) begin
      fwd_op <= s1_fire ? s1_req.op : svfd_pkg::OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_addr <= s1_req.addr;
      fwd_data <= new_entry;
    end
  end

  // Merge forwarded write into the registered reads
  always_comb begin
    old_tgt = rd_tgt;
    old_idx = rd_idx;
    if (fwd_op == svfd_pkg::OP_CLEAR) begin
      old_tgt = svfd_pkg::ENTRY_RESET;
      old_idx = svfd_pkg::ENTRY_RESET;
    end else if (fwd_op == svfd_pkg::OP_POINT || fwd_op == svfd_pkg::OP_CHAR) begin
      if (fwd_addr == s1_req.addr) begin
        old_tgt = fwd_data;
      end
      if (fwd_addr == s1_read_index) begin
        old_idx = fwd_data;
      end
    end
  end

  // Apply the RAM operation and build the result word
  always_comb begin
    new_entry = old_tgt;
    disp      = 1'b0;
    wr_en     = 1'b0;
    clr       = 1'b0;
    unique case (s1_req.op)
      svfd_pkg::OP_POINT: begin
        new_entry.point = old_tgt.point | s1_req.value[5:0];
        disp            = (old_tgt.point == 6'd0);
        wr_en           = s1_fire;
      end
      svfd_pkg::OP_CHAR: begin
        new_entry.point = 6'd0;
        new_entry.chr   = s1_req.value;
        disp            = (old_tgt.chr != s1_req.value);
        wr_en           = s1_fire;
      end
      svfd_pkg::OP_CLEAR: begin
        disp = 1'b1;
        clr  = s1_fire;
      end
      svfd_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase

    result_next.disp_pulse  = disp;
    result_next.duty_pulse  = s1_inten;
    result_next.intensity   = s1_ctrl.duty;
    result_next.digit_count = s1_ctrl.digits;
    result_next.cursor      = s1_ctrl.cursor;
    result_next.is_enabled  = s1_ctrl.enabled;
    if (s1_req.op == svfd_pkg::OP_CLEAR) begin
      result_next.read_char  = svfd_pkg::ENTRY_RESET.chr;
      result_next.read_point = svfd_pkg::ENTRY_RESET.point;
    end else if ((s1_req.op == svfd_pkg::OP_POINT || s1_req.op == svfd_pkg::OP_CHAR)
                 && s1_req.addr == s1_read_index) begin
      result_next.read_char  = new_entry.chr;
      result_next.read_point = new_entry.point;
    end else begin
      result_next.read_char  = old_idx.chr;
      result_next.read_point = old_idx.point;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= result_next;
    end
  end

endmodule

[bench/tb_serial_vfd_display_controller.sv]
`timescale 1ns / 1ps
// Self-checking bench for the serial VFD controller with an inline predictor.
module tb_serial_vfd_display_controller;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int IDLE_PCT    = 34;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  svfd_pkg::item_t   item = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  svfd_pkg::result_t result;

  // Display state tracked word by word
  logic              vfd_on;
  logic              vfd_clk;
  logic [7:0]        vfd_shift;
  int                vfd_bits;
  logic [3:0]        vfd_cursor;
  logic [4:0]        vfd_duty;
  logic [4:0]        vfd_digits;
  svfd_pkg::entry_t  vfd_ram [svfd_pkg::DIGITS];

  svfd_pkg::result_t display_reports [$];
  int                word_count = 0;
  int                mismatches = 0;
  int                cycles = 0;
  logic              steady = 1'b0;
  int                hold_req_count = 0;
  int                hold_done_count = 0;
  int                hold_left = 0;

  serial_vfd_display_controller dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Return the controller to its power-on contents
  function automatic void vfd_clear();
    vfd_clk    = 1'b0;
    vfd_cursor = svfd_pkg::CURSOR_RESET;
    vfd_bits   = 0;
    vfd_digits = 5'd0;
    vfd_duty   = 5'd0;
    vfd_shift  = 8'd0;
    for (int i = 0; i < svfd_pkg::DIGITS; i++) vfd_ram[i] = svfd_pkg::ENTRY_RESET;
  endfunction

  // Decode one complete byte into a command or a character write
  function automatic void vfd_take_byte(input logic [7:0] b, inout logic disp,
                                        inout logic inten);
    logic [6:0] c;
    if (!vfd_on) return;
    case (b[7:5])
      svfd_pkg::GRP_DUTY: begin
        if (vfd_duty != b[4:0]) begin
          vfd_duty = b[4:0];
          inten = 1'b1;
        end
      end
      svfd_pkg::GRP_CURSOR: vfd_cursor = b[3:0];
      svfd_pkg::GRP_TEST: ;
      svfd_pkg::GRP_DIGITS:
        vfd_digits = (b[4:0] == 5'd0) ? svfd_pkg::DIGITS_DEFAULT : b[4:0];
      default: begin
        c = {1'b0, b[5:0]};
        if (c == 7'd0) c = svfd_pkg::CHAR_NULL_SUB;
        if (c == svfd_pkg::CHAR_DOT || c == svfd_pkg::CHAR_COMMA) begin
          // OR the mark into the current entry
          if (vfd_ram[vfd_cursor].point == 6'd0) disp = 1'b1;
          vfd_ram[vfd_cursor].point = vfd_ram[vfd_cursor].point | c[5:0];
        end else begin
          vfd_cursor = vfd_cursor + 4'd1;
          if (vfd_ram[vfd_cursor].chr != c) disp = 1'b1;
          vfd_ram[vfd_cursor].chr   = c;
          vfd_ram[vfd_cursor].point = 6'd0;
        end
      end
    endcase
  endfunction

  // Apply one accepted word and form the report it must produce
  function automatic svfd_pkg::result_t vfd_update(input svfd_pkg::item_t w);
    svfd_pkg::result_t r;
    logic              disp;
    logic              inten;
    disp  = 1'b0;
    inten = 1'b0;
    if (w.cmd) begin
      vfd_take_byte(w.byte_value, disp, inten);
    end else if (!w.enable_line) begin
      if (vfd_on) begin
        vfd_clear();
        disp  = 1'b1;
        inten = 1'b1;
      end
      vfd_on  = 1'b0;
      vfd_clk = w.clock_line;
    end else begin
      vfd_on = 1'b1;
      if (w.clock_line != vfd_clk) begin
        // Shift on the falling edge, MSB first
        if (!w.clock_line) begin
          vfd_shift = {vfd_shift[6:0], w.data_line};
          vfd_bits++;
          if (vfd_bits >= 8) begin
            vfd_bits = 0;
            vfd_take_byte(vfd_shift, disp, inten);
          end
        end
        vfd_clk = w.clock_line;
      end
    end
    r.disp_pulse  = disp;
    r.duty_pulse  = inten;
    r.intensity   = vfd_duty;
    r.digit_count = vfd_digits;
    r.cursor      = vfd_cursor;
    r.is_enabled  = vfd_on;
    r.read_char   = vfd_ram[w.read_index].chr;
    r.read_point  = vfd_ram[w.read_index].point;
    return r;
  endfunction

  // Offer one word, idling cycle by cycle at random, and log its report on acceptance
  task automatic send_word(input svfd_pkg::item_t w);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    do @(posedge clk); while (!item_ready);
    display_reports.push_back(vfd_update(w));
    word_count++;
  endtask

  // Favor the entry under the cursor so writes get read back
  function automatic logic [3:0] pick_index();
    return $urandom_range(1) ? vfd_cursor : 4'($urandom_range(svfd_pkg::DIGITS - 1));
  endfunction

  task automatic pin(input logic en, input logic ck, input logic dt);
    svfd_pkg::item_t w;
    w.cmd         = 1'b0;
    w.enable_line = en;
    w.clock_line  = ck;
    w.data_line   = dt;
    w.byte_value  = 8'($urandom);
    w.read_index  = pick_index();
    send_word(w);
  endtask

  task automatic direct(input logic [7:0] b);
    svfd_pkg::item_t w;
    w.cmd         = 1'b1;
    w.enable_line = 1'($urandom);
    w.clock_line  = 1'($urandom);
    w.data_line   = 1'($urandom);
    w.byte_value  = b;
    w.read_index  = pick_index();
    send_word(w);
  endtask

  // Clock a byte in over the pins, or only its first bits
  task automatic shift_serial(input logic [7:0] b, input int nbits);
    for (int i = 7; i > 7 - nbits; i--) begin
      pin(1'b1, 1'b1, b[i]);
      pin(1'b1, 1'b0, b[i]);
    end
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(9))
      0: return {svfd_pkg::GRP_DUTY, 5'($urandom)};
      1: return {svfd_pkg::GRP_CURSOR, 5'($urandom)};
      2: return {svfd_pkg::GRP_TEST, 5'($urandom)};
      3: return {svfd_pkg::GRP_DIGITS, 5'($urandom)};
      4: return {1'b0, 1'($urandom), svfd_pkg::CHAR_DOT[5:0]};
      5: return {1'b0, 1'($urandom), svfd_pkg::CHAR_COMMA[5:0]};
      6: return {1'b0, 1'($urandom), 6'd0};
      default: return {1'b0, 7'($urandom)};
    endcase
  endfunction

  task automatic wait_drained();
    while (display_reports.size() != 0) @(posedge clk);
  endtask

  // Drop the receiver's ready at random, or hold it off when asked
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_req_count != hold_done_count) begin
      result_ready    <= 1'b0;
      hold_left       <= HOLD_CYCLES;
      hold_done_count <= hold_done_count + 1;
    end else begin
      result_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Check every accepted report against the oldest one logged
  always @(posedge clk) begin
    svfd_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (display_reports.size() == 0) begin
        $error("report with no word outstanding");
        mismatches++;
      end else begin
        want = display_reports.pop_front();
        compare_field("disp_pulse", want.disp_pulse, result.disp_pulse);
        compare_field("duty_pulse", want.duty_pulse, result.duty_pulse);
        compare_field("intensity", want.intensity, result.intensity);
        compare_field("digit_count", want.digit_count, result.digit_count);
        compare_field("cursor", want.cursor, result.cursor);
        compare_field("is_enabled", want.is_enabled, result.is_enabled);
        compare_field("read_char", want.read_char, result.read_char);
        compare_field("read_point", want.read_point, result.read_point);
      end
    end
  end

  // Bytes while disabled are dropped; enable low only samples the clock
  task automatic test_disabled_controller();
    direct({svfd_pkg::GRP_DUTY, 5'd5});
    pin(1'b0, 1'b1, 1'b0);
    pin(1'b0, 1'b0, 1'b1);
  endtask

  task automatic test_command_decode();
    pin(1'b1, 1'b0, 1'b0);
    direct({svfd_pkg::GRP_DUTY, 5'd31});
    direct({svfd_pkg::GRP_DUTY, 5'd0});
    direct({svfd_pkg::GRP_DUTY, 5'd0});
    direct({svfd_pkg::GRP_CURSOR, 5'd31});
    direct({svfd_pkg::GRP_CURSOR, 5'd0});
    direct({svfd_pkg::GRP_TEST, 5'd31});
    direct({svfd_pkg::GRP_DIGITS, 5'd0});
    direct({svfd_pkg::GRP_DIGITS, 5'd31});
    direct(8'h00);
    direct(8'h3F);
    direct(8'h41);
    direct(8'h7F);
  endtask

  // Dot then comma on one entry accumulates to the dot code
  task automatic test_point_marks();
    direct({2'b00, svfd_pkg::CHAR_DOT[5:0]});
    direct({2'b01, svfd_pkg::CHAR_COMMA[5:0]});
    direct({2'b01, svfd_pkg::CHAR_DOT[5:0]});
  endtask

  // Enable low while enabled clears everything and drops a partial byte
  task automatic test_disable_reset();
    shift_serial(8'hFF, 1);
    pin(1'b0, 1'b0, 1'b0);
    pin(1'b0, 1'b1, 1'b1);
    pin(1'b1, 1'b1, 1'b0);
  endtask

  task automatic random_traffic(input int n);
    int target;
    int k;
    target = word_count + n;
    while (word_count < target) begin
      k = $urandom_range(99);
      if (k < 45) begin
        shift_serial(random_byte(), 8);
      end else if (k < 80) begin
        repeat ($urandom_range(1, 6)) direct(random_byte());
      end else if (k < 90) begin
        repeat ($urandom_range(1, 4)) pin(1'($urandom), 1'($urandom), 1'($urandom));
      end else if (k < 95) begin
        pin(1'b0, 1'($urandom), 1'($urandom));
        pin(1'b1, 1'($urandom), 1'($urandom));
      end else begin
        shift_serial(8'($urandom), $urandom_range(1, 7));
      end
    end
  endtask

  // Hold the receiver off while words keep coming so the input backs up
  task automatic test_output_stall();
    hold_req_count <= hold_req_count + 1;
    random_traffic(60);
  endtask

  task automatic test_steady_stream();
    steady <= 1'b1;
    random_traffic(250);
    steady <= 1'b0;
  endtask

  task automatic test_paused_sender();
    item_valid <= 1'b0;
    wait_drained();
    random_traffic(200);
  endtask

  initial begin
    vfd_clear();
    vfd_on = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_disabled_controller();
    test_command_decode();
    test_point_marks();
    test_disable_reset();
    random_traffic(350);
    test_output_stall();
    test_steady_stream();
    test_paused_sender();
    random_traffic(350);

    item_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && display_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
